FILE: src/gb3_pkg.sv
// Shared types and constants for the 3x3 Gaussian blur core.
// No dependencies; imported by every module of the core.
package gb3_pkg;

  // Fixed field widths of the pixel, result and configuration ports
  localparam int PIX_W   = 8;
  localparam int ROW_W   = 12;
  localparam int COL_W   = 10;
  localparam int IMG_W_W = 11;
  localparam int IMG_H_W = 13;
  localparam int CFG_W   = 13;
  localparam int CFG_IDX_W = 2;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = 2'd1;

  // Reset values of the frame size registers
  localparam logic [IMG_W_W-1:0] RESET_WIDTH  = 11'd512;
  localparam logic [IMG_H_W-1:0] RESET_HEIGHT = 13'd512;

  // Default maximum frame size
  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 4096;

  // Smallest frame dimension the filter supports
  localparam int MIN_DIM = 3;

  // Kernel 1 2 1 / 2 4 2 / 1 2 1 over 16: each tap is pixel * w / 16 with
  // w a power of two, i.e. a right shift by 4 - log2(w)
  localparam int unsigned KERN_SHIFT [9] = '{4, 3, 4, 3, 2, 3, 4, 3, 4};

  // Job queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // One completed window: its blurred value and the coordinates it covers
  typedef struct packed {
    logic [PIX_W-1:0] value;
    logic [ROW_W-1:0] row_mid;
    logic [ROW_W-1:0] row_end;
    logic             row_lo;
    logic             row_hi;
    logic [COL_W-1:0] col_mid;
    logic [COL_W-1:0] col_end;
    logic             col_lo;
    logic             col_hi;
  } gb3_job_t;

endpackage

FILE: src/gb3_queue.sv
// Small job FIFO between the blur front end and the result expander.
// Depends on gb3_pkg for the job type and depth.
module gb3_queue
  import gb3_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  gb3_job_t          push_job,
  input  logic              pop,
  output gb3_job_t          head,
  output logic              not_empty,
  output logic [QCNT_W-1:0] count
);

  gb3_job_t          q_mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= push_job;
    end
  end

  assign head      = q_mem_r[rd_ptr_r];
  assign not_empty = (count_r != '0);
  assign count     = count_r;

endmodule

FILE: src/gb3_front.sv
// Front end: pixel acceptance, raster counters, line store, 3x3 window and
// blur sum; pushes one job per completed window. Depends on gb3_pkg.
module gb3_front
  import gb3_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int WEW        = $clog2(MAX_WIDTH + 1),
  parameter int HEW        = $clog2(MAX_HEIGHT + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              restart,
  input  logic [WEW-1:0]    img_w,
  input  logic [HEW-1:0]    img_h,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [PIX_W-1:0]  in_pixel,
  input  logic [QCNT_W-1:0] q_count,
  output logic              push,
  output gb3_job_t          push_job
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);

  function automatic logic [PIX_W-1:0] blur(input logic [PIX_W-1:0] win [9]);
    logic [PIX_W+3:0] s;
    s = '0;
    for (int i = 0; i < 9; i++) begin
      s = s + (PIX_W+4)'(win[i] >> KERN_SHIFT[i]);
    end
    return s[PIX_W-1:0];
  endfunction

  logic              acc;
  logic [CW-1:0]     col_r, col_nxt;
  logic [RW-1:0]     row_r, row_nxt;
  logic [CW-1:0]     w_last;
  logic [RW-1:0]     h_last;

  // line store: upper byte is line r-1, lower byte line r-2
  logic [2*PIX_W-1:0] lstore [MAX_WIDTH];
  logic [2*PIX_W-1:0] rd_q_r;

  logic              s1_v_r, s2_v_r;
  logic [PIX_W-1:0]  s1_pix_r;
  logic [CW-1:0]     s1_col_r;
  logic              s1_emit_r, s2_emit_r;
  gb3_job_t          s0_job, s1_job_r, s2_job_r;
  logic [PIX_W-1:0]  win_r [9];
  logic [PIX_W-1:0]  win_nxt [9];
  logic [QCNT_W:0]   occupancy;

  assign w_last = CW'(img_w - 1'b1);
  assign h_last = RW'(img_h - 1'b1);

  // every item in flight holds a queue slot, so the queue never overflows
  assign occupancy = (QCNT_W+1)'(q_count) + (QCNT_W+1)'(s1_v_r) + (QCNT_W+1)'(s2_v_r);
  assign in_ready  = (occupancy < (QCNT_W+1)'(QUEUE_DEPTH));
  assign acc       = in_valid && in_ready;

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (restart) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (acc) begin
      if (col_r == w_last) begin
        col_nxt = '0;
        row_nxt = (row_r == h_last) ? '0 : row_r + 1'b1;
      end else begin
        col_nxt = col_r + 1'b1;
      end
    end
  end

  // classify at acceptance: window centre is (row-1, col-1)
  always_comb begin
    s0_job         = '0;
    s0_job.row_mid = ROW_W'(row_r - 1'b1);
    s0_job.row_end = ROW_W'(h_last);
    s0_job.row_lo  = (row_r == RW'(2));
    s0_job.row_hi  = (row_r == h_last);
    s0_job.col_mid = COL_W'(col_r - 1'b1);
    s0_job.col_end = COL_W'(w_last);
    s0_job.col_lo  = (col_r == CW'(2));
    s0_job.col_hi  = (col_r == w_last);
  end

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      win_nxt[i] = win_r[i];
    end
    if (s1_v_r) begin
      win_nxt[0] = win_r[1];
      win_nxt[1] = win_r[2];
      win_nxt[2] = rd_q_r[PIX_W-1:0];
      win_nxt[3] = win_r[4];
      win_nxt[4] = win_r[5];
      win_nxt[5] = rd_q_r[2*PIX_W-1:PIX_W];
      win_nxt[6] = win_r[7];
      win_nxt[7] = win_r[8];
      win_nxt[8] = s1_pix_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r     <= '0;
      row_r     <= '0;
      s1_v_r    <= 1'b0;
      s2_v_r    <= 1'b0;
      s1_emit_r <= 1'b0;
      s2_emit_r <= 1'b0;
      for (int i = 0; i < 9; i++) begin
        win_r[i] <= '0;
      end
    end else begin
      col_r     <= col_nxt;
      row_r     <= row_nxt;
      s1_v_r    <= acc;
      s2_v_r    <= s1_v_r;
      s1_emit_r <= acc && (row_r >= RW'(2)) && (col_r >= CW'(2));
      s2_emit_r <= s1_v_r && s1_emit_r;
      for (int i = 0; i < 9; i++) begin
        win_r[i] <= win_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_pix_r <= in_pixel;
      s1_col_r <= col_r;
      s1_job_r <= s0_job;
    end
    if (s1_v_r) begin
      s2_job_r <= s1_job_r;
    end
  end

  // read at acceptance, write back the shifted pair in the next cycle
  always_ff @(posedge clk) begin
    if (acc) begin
      rd_q_r <= lstore[col_r];
    end
    if (s1_v_r) begin
      lstore[s1_col_r] <= {s1_pix_r, rd_q_r[2*PIX_W-1:PIX_W]};
    end
  end

  always_comb begin
    push_job       = s2_job_r;
    push_job.value = blur(win_r);
  end

  assign push = s2_v_r && s2_emit_r;

endmodule

FILE: src/gb3_back.sv
// Back end: expands each job into its 1 to 9 result items and holds them
// in the output register. Depends on gb3_pkg for the job type.
module gb3_back
  import gb3_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  gb3_job_t         head,
  input  logic             not_empty,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [PIX_W-1:0] out_value,
  output logic [ROW_W-1:0] out_row,
  output logic [COL_W-1:0] out_col,
  output logic             out_last
);

  logic [1:0]       ri_r, ri_nxt;
  logic [1:0]       ci_r, ci_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [PIX_W-1:0] out_value_r;
  logic [ROW_W-1:0] out_row_r;
  logic [COL_W-1:0] out_col_r;
  logic             out_last_r;
  logic             load;
  logic             last_ri, last_ci;
  logic [ROW_W-1:0] sel_row;
  logic [COL_W-1:0] sel_col;

  assign load    = not_empty && (!out_valid_r || out_ready);
  assign last_ri = (ri_r == (2'(head.row_lo) + 2'(head.row_hi)));
  assign last_ci = (ci_r == (2'(head.col_lo) + 2'(head.col_hi)));
  assign pop     = load && last_ri && last_ci;

  // rows and columns ascending: low edge copy, centre, high edge copy
  always_comb begin
    case (ri_r)
      2'd0:    sel_row = head.row_lo ? '0 : head.row_mid;
      2'd1:    sel_row = head.row_lo ? head.row_mid : head.row_end;
      default: sel_row = head.row_end;
    endcase
    case (ci_r)
      2'd0:    sel_col = head.col_lo ? '0 : head.col_mid;
      2'd1:    sel_col = head.col_lo ? head.col_mid : head.col_end;
      default: sel_col = head.col_end;
    endcase
  end

  always_comb begin
    ri_nxt        = ri_r;
    ci_nxt        = ci_r;
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
      if (last_ci) begin
        ci_nxt = '0;
        ri_nxt = last_ri ? '0 : ri_r + 1'b1;
      end else begin
        ci_nxt = ci_r + 1'b1;
      end
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ri_r        <= '0;
      ci_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      ri_r        <= ri_nxt;
      ci_r        <= ci_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_value_r <= head.value;
      out_row_r   <= sel_row;
      out_col_r   <= sel_col;
      out_last_r  <= last_ri && last_ci;
    end
  end

  assign out_valid = out_valid_r;
  assign out_value = out_value_r;
  assign out_row   = out_row_r;
  assign out_col   = out_col_r;
  assign out_last  = out_last_r;

endmodule

FILE: src/gaussian_blur_3x3_replicate_border_core.sv
// 3x3 Gaussian blur (1 2 1 / 2 4 2 / 1 2 1 over 16) with replicated borders.
// Top level; instantiates gb3_front, gb3_queue and gb3_back from gb3_pkg.
//
// Pixels enter in raster order, one per transfer on the in_ channel, and
// the core sustains one pixel per clock while in_ready is high. Each pixel
// that completes a 3x3 window (row and column both at least 2) yields the
// blurred centre value together with its replicated edge and corner copies:
// one result for an interior centre, up to nine at a frame corner, each on
// its own out_ transfer with its coordinates and out_last marking the final
// one for that pixel. A pixel passes two front stages before it enters the
// job queue, and its first result is loaded once it heads the queue and the
// output register is free. That register issues one result per cycle while
// out_ready is high, so an item with k results takes k transfers on the
// result side; the four-entry job queue absorbs these edge bursts and
// in_ready drops only when queued jobs and items in the two front stages
// fill all four slots. The line store is a single MAX_WIDTH x 16-bit
// memory, read when a pixel is taken and written back the next cycle; it
// needs no clearing pass after reset. Each tap is truncated on its own
// (pixel * weight / 16, rounded down) before the nine are summed. Frame
// size is set through cfg_: index 0 is pixels per line, index 1 lines per
// frame, each held to [3, MAX_*]; any write to a known index restarts the
// frame at row 0, column 0. Write them only while the core is idle.
module gaussian_blur_3x3_replicate_border_core
  import gb3_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // pixel input
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [PIX_W-1:0]     in_pixel,
  // results
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [PIX_W-1:0]     out_value,
  output logic [ROW_W-1:0]     out_row,
  output logic [COL_W-1:0]     out_col,
  output logic                 out_last,
  // configuration writes
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int WEW = $clog2(MAX_WIDTH + 1);
  localparam int HEW = $clog2(MAX_HEIGHT + 1);

  logic [IMG_W_W-1:0] image_width_r, image_width_nxt;
  logic [IMG_H_W-1:0] image_height_r, image_height_nxt;
  logic               restart;
  logic [WEW-1:0]     w_eff;
  logic [HEW-1:0]     h_eff;

  logic               push, pop, q_not_empty;
  gb3_job_t           push_job, q_head;
  logic [QCNT_W-1:0]  q_count;

  // Register writes; an unknown index is dropped and does not restart.
  always_comb begin
    image_width_nxt  = image_width_r;
    image_height_nxt = image_height_r;
    restart          = 1'b0;
    if (cfg_wr_en) begin
      case (cfg_index)
        CFG_IDX_WIDTH: begin
          image_width_nxt = cfg_data[IMG_W_W-1:0];
          restart         = 1'b1;
        end
        CFG_IDX_HEIGHT: begin
          image_height_nxt = cfg_data[IMG_H_W-1:0];
          restart          = 1'b1;
        end
        default: restart = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r  <= RESET_WIDTH;
      image_height_r <= RESET_HEIGHT;
    end else begin
      image_width_r  <= image_width_nxt;
      image_height_r <= image_height_nxt;
    end
  end

  // Hold the frame size inside the supported range.
  always_comb begin
    if (32'(image_width_r) < MIN_DIM) begin
      w_eff = WEW'(MIN_DIM);
    end else if (32'(image_width_r) > MAX_WIDTH) begin
      w_eff = WEW'(MAX_WIDTH);
    end else begin
      w_eff = WEW'(image_width_r);
    end
    if (32'(image_height_r) < MIN_DIM) begin
      h_eff = HEW'(MIN_DIM);
    end else if (32'(image_height_r) > MAX_HEIGHT) begin
      h_eff = HEW'(MAX_HEIGHT);
    end else begin
      h_eff = HEW'(image_height_r);
    end
  end

  gb3_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .WEW        (WEW),
    .HEW        (HEW)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .restart  (restart),
    .img_w    (w_eff),
    .img_h    (h_eff),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_pixel (in_pixel),
    .q_count  (q_count),
    .push     (push),
    .push_job (push_job)
  );

  gb3_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_job  (push_job),
    .pop       (pop),
    .head      (q_head),
    .not_empty (q_not_empty),
    .count     (q_count)
  );

  gb3_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (q_head),
    .not_empty (q_not_empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_value (out_value),
    .out_row   (out_row),
    .out_col   (out_col),
    .out_last  (out_last)
  );

endmodule

FILE: tb/sv/tb_gaussian_blur_3x3_replicate_border_core.sv
`timescale 1ns / 1ps
// Self-checking testbench for gaussian_blur_3x3_replicate_border_core.
// Needs gb3_pkg and the core RTL only; it predicts every result transfer
// from its own copy of the line stores and window, then checks it.

module tb_gaussian_blur_3x3_replicate_border_core;
  import gb3_pkg::*;

  localparam int MAX_W = DEF_MAX_WIDTH;
  localparam int MAX_H = DEF_MAX_HEIGHT;

  // Register indexes past the end of the list: the core must ignore them
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_HI = 2'd3;

  // Kernel weights in sixteenths, raster order over the 3x3 window
  localparam int unsigned TAP_WEIGHT [9] = '{1, 2, 1, 2, 4, 2, 1, 2, 1};

  // A pixel passes through the two front stages before it reaches the job
  // queue, and its first result shows once it heads the queue, so a pixel with
  // no result can sit in the front stages after the last result has gone.
  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES   = 20;
  localparam int STUCK_LIMIT   = 2000;
  localparam int RANDOM_ITEMS  = 260;

  // A few hand-picked pixels for the directed frame
  localparam logic [PIX_W-1:0] MIXED_FRAME [9] =
    '{8'h00, 8'h80, 8'h7F, 8'h01, 8'hFE, 8'h55, 8'hAA, 8'h0F, 8'hF0};

  typedef struct packed {
    logic [PIX_W-1:0] value;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             last;
  } blur_result_t;

  logic                 clk;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  logic [PIX_W-1:0]     in_pixel  = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [PIX_W-1:0]     out_value;
  logic [ROW_W-1:0]     out_row;
  logic [COL_W-1:0]     out_col;
  logic                 out_last;
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data  = '0;

  // Pixels waiting to be sent, and blurred results waiting to arrive
  logic [PIX_W-1:0] pixel_q [$];
  blur_result_t     blurred_q [$];

  // Predictor state: two previous lines, the window and the raster position
  logic [PIX_W-1:0]   line_above  [MAX_W] = '{default: '0};
  logic [PIX_W-1:0]   line_above2 [MAX_W] = '{default: '0};
  logic [PIX_W-1:0]   nbhd [9]            = '{default: '0};
  int unsigned        next_col = 0;
  int unsigned        next_row = 0;
  logic [IMG_W_W-1:0] width_reg  = RESET_WIDTH;
  logic [IMG_H_W-1:0] height_reg = RESET_HEIGHT;

  int           idle_pct     = 0;   // chance in percent of starting an idle burst
  int           feed_gap     = 0;
  int           sink_stall   = 0;
  int           stuck_cycles = 0;
  int           error_count  = 0;
  int unsigned  results_seen = 0;
  blur_result_t head_result;

  gaussian_blur_3x3_replicate_border_core #(
    .MAX_WIDTH (MAX_W),
    .MAX_HEIGHT(MAX_H)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_pixel (in_pixel),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_value(out_value),
    .out_row  (out_row),
    .out_col  (out_col),
    .out_last (out_last),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Frame sizes saturate into [MIN_DIM, max]
  function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned hi);
    if (v < MIN_DIM) return MIN_DIM;
    if (v > hi) return hi;
    return v;
  endfunction

  // Lean towards the extremes so every pixel bit sees both values often
  function automatic logic [PIX_W-1:0] pick_pixel();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return PIX_W'($urandom_range(255));
    endcase
  endfunction

  // Mostly small frames; sometimes below the minimum, and for the width
  // sometimes with junk in the bits above the register
  function automatic logic [CFG_W-1:0] random_dim(input bit is_width);
    case ($urandom_range(7))
      0: return CFG_W'($urandom_range(0, 2));
      1: return is_width ? (CFG_W'($urandom_range(3, 9)) | 13'h1800)
                         : CFG_W'($urandom_range(3, 9));
      default: return CFG_W'($urandom_range(3, 9));
    endcase
  endfunction

  task automatic flag_error(input string msg);
    $display("[%0t] ERROR: %s", $time, msg);
    error_count++;
  endtask

  // Advance the blur predictor by one accepted pixel and queue its results:
  // the centre value plus edge and corner copies, rows then columns ascending.
  task automatic blur_pixel(input logic [PIX_W-1:0] pix);
    int unsigned w, h, c, r, acc, cr, cc, nr, nc, i, j;
    int unsigned row_set [3];
    int unsigned col_set [3];
    logic [PIX_W-1:0] above, above2;
    blur_result_t res;
    w = clamp_dim(width_reg, MAX_W);
    h = clamp_dim(height_reg, MAX_H);
    c = (next_col >= w) ? 0 : next_col;
    r = (next_row >= h) ? 0 : next_row;
    above2 = line_above2[c];
    above  = line_above[c];
    line_above2[c] = above;
    line_above[c]  = pix;
    for (i = 0; i < 3; i++) begin
      nbhd[3*i]   = nbhd[3*i+1];
      nbhd[3*i+1] = nbhd[3*i+2];
    end
    nbhd[2] = above2;
    nbhd[5] = above;
    nbhd[8] = pix;
    if (r >= 2 && c >= 2) begin
      acc = 0;
      for (i = 0; i < 9; i++) acc += (nbhd[i] * TAP_WEIGHT[i]) >> 4;
      cr = r - 1;
      cc = c - 1;
      nr = 0;
      nc = 0;
      if (cr == 1) row_set[nr++] = 0;
      row_set[nr++] = cr;
      if (cr == h - 2) row_set[nr++] = h - 1;
      if (cc == 1) col_set[nc++] = 0;
      col_set[nc++] = cc;
      if (cc == w - 2) col_set[nc++] = w - 1;
      for (i = 0; i < nr; i++) begin
        for (j = 0; j < nc; j++) begin
          res.value = PIX_W'(acc);
          res.row   = ROW_W'(row_set[i]);
          res.col   = COL_W'(col_set[j]);
          res.last  = (i == nr - 1) && (j == nc - 1);
          blurred_q.push_back(res);
        end
      end
    end
    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h) r = 0;
    end
    next_col = c;
    next_row = r;
  endtask

  // Pixel driver: hold valid and payload until the transfer, then load the
  // next pixel or drop into an idle burst.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      feed_gap <= 0;
    end else begin
      if (in_valid && in_ready) blur_pixel(in_pixel);
      if (!in_valid || in_ready) begin
        if (feed_gap != 0) begin
          in_valid <= 1'b0;
          feed_gap <= feed_gap - 1;
        end else if (pixel_q.size() != 0 && idle_pct != 0 &&
                     $urandom_range(99) < idle_pct) begin
          in_valid <= 1'b0;
          feed_gap <= $urandom_range(14);
        end else if (pixel_q.size() != 0) begin
          in_valid <= 1'b1;
          in_pixel <= pixel_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compare each transfer with the oldest blurred result,
  // field by field, and stall the result side in bursts.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready  <= 1'b0;
      sink_stall <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (blurred_q.size() == 0) begin
          flag_error($sformatf("unexpected result value %0d at (%0d,%0d) last %0b",
                               out_value, out_row, out_col, out_last));
        end else begin
          head_result = blurred_q.pop_front();
          if (out_value !== head_result.value)
            flag_error($sformatf("result %0d: value %0d, want %0d",
                                 results_seen, out_value, head_result.value));
          if (out_row !== head_result.row)
            flag_error($sformatf("result %0d: row %0d, want %0d",
                                 results_seen, out_row, head_result.row));
          if (out_col !== head_result.col)
            flag_error($sformatf("result %0d: col %0d, want %0d",
                                 results_seen, out_col, head_result.col));
          if (out_last !== head_result.last)
            flag_error($sformatf("result %0d: last %0b, want %0b",
                                 results_seen, out_last, head_result.last));
        end
        results_seen++;
      end
      if (sink_stall != 0) begin
        out_ready  <= 1'b0;
        sink_stall <= sink_stall - 1;
      end else if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
        out_ready  <= 1'b0;
        sink_stall <= $urandom_range(14);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog: end the run if neither channel moves a transfer for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Block until every pixel has been taken and every result has come back.
  // Sample on the falling edge, clear of the driver's updates.
  task automatic wait_drained();
    do @(negedge clk);
    while (pixel_q.size() != 0 || in_valid || blurred_q.size() != 0);
  endtask

  // Raise a register write for one edge and mirror it in the predictor;
  // writes to known indexes restart the frame. Follow with cfg_release.
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      CFG_IDX_WIDTH: begin
        width_reg = data[IMG_W_W-1:0];
        next_col  = 0;
        next_row  = 0;
      end
      CFG_IDX_HEIGHT: begin
        height_reg = data[IMG_H_W-1:0];
        next_col   = 0;
        next_row   = 0;
      end
      default: ;
    endcase
  endtask

  task automatic cfg_release();
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  // Let the core go quiet, then set a new frame size
  task automatic resize_frame(input logic [CFG_W-1:0] w_data, input logic [CFG_W-1:0] h_data,
                              input bit with_spare);
    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_write(CFG_IDX_WIDTH, w_data);
    if (with_spare) cfg_write(CFG_IDX_SPARE_HI, ~h_data);
    cfg_write(CFG_IDX_HEIGHT, h_data);
    cfg_release();
  endtask

  task automatic queue_pixels(input int unsigned n);
    repeat (n) pixel_q.push_back(pick_pixel());
  endtask

  initial begin : stimulus
    int unsigned frame_px, batch, random_fed, i;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Smallest frame, all white: the single window gives the largest sum
    // and all nine corner and edge copies.
    resize_frame(13'd3, 13'd3, 1'b0);
    repeat (9) pixel_q.push_back('1);

    // Next frame wraps straight on; part way through, write the unused
    // indexes, which must neither take effect nor restart the frame.
    for (i = 0; i < 4; i++) pixel_q.push_back(MIXED_FRAME[i]);
    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_write(CFG_IDX_SPARE_LO, 13'h1FFF);
    cfg_write(CFG_IDX_SPARE_HI, 13'h0000);
    cfg_release();
    for (i = 4; i < 9; i++) pixel_q.push_back(MIXED_FRAME[i]);

    // Two pixels into a frame, then a width write: the frame restarts
    pixel_q.push_back(8'h33);
    pixel_q.push_back(8'hCC);
    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_write(CFG_IDX_WIDTH, 13'd4);
    cfg_release();

    // Random batches on small frames: whole frames mostly, partial ones
    // too; carry on mid-frame, hold off until drained, or resize.
    random_fed = 0;
    while (random_fed < RANDOM_ITEMS) begin
      case ($urandom_range(3))
        0:       idle_pct = 0;
        1:       idle_pct = 5;
        2:       idle_pct = 15;
        default: idle_pct = 30;
      endcase
      frame_px = clamp_dim(width_reg, MAX_W) * clamp_dim(height_reg, MAX_H);
      if ($urandom_range(3) == 0) batch = $urandom_range(1, frame_px);
      else batch = frame_px * $urandom_range(1, 2);
      queue_pixels(batch);
      random_fed += batch;
      case ($urandom_range(2))
        0:       ;
        1:       wait_drained();
        default: resize_frame(random_dim(1'b1), random_dim(1'b0), $urandom_range(3) == 0);
      endcase
    end

    // Tall frame: width field junk above bit 10, height saturates to the
    // maximum, so the first rows carry no bottom edge copies.
    idle_pct = 10;
    resize_frame(13'h1803, 13'h1FFF, 1'b1);
    queue_pixels(3 * 6);

    // Wide frame: width saturates to the maximum, height to the minimum;
    // the start of the first line must give no result.
    resize_frame(13'h1FFF, 13'h0000, 1'b0);
    queue_pixels(40);

    // Closing stretch with both sides flat out
    idle_pct = 0;
    resize_frame(13'd6, 13'd5, 1'b0);
    queue_pixels(60);

    wait_drained();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/gb3_pkg.sv
src/gb3_queue.sv
src/gb3_front.sv
src/gb3_back.sv
src/gaussian_blur_3x3_replicate_border_core.sv
tb/sv/tb_gaussian_blur_3x3_replicate_border_core.sv
